FILE: src/crc32_append_encoder_top_defines.svh
`ifndef CRC32_APPEND_ENCODER_TOP_DEFINES_SVH
`define CRC32_APPEND_ENCODER_TOP_DEFINES_SVH

// Concurrent check that is switched off while reset is held.
`define CRC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also applies across reset.
`define CRC_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/crc32ae_pkg.sv
`default_nettype none

package crc32ae_pkg;

    localparam int BYTE_W      = 8;
    localparam int CRC_W       = 32;
    localparam int CHECK_BYTES = CRC_W / BYTE_W;
    localparam int CNT_W       = $clog2(CHECK_BYTES + 1);

    localparam logic [CRC_W-1:0] CRC_GEN = 32'h04C1_1DB7;

    typedef struct packed {
        logic [BYTE_W-1:0] msg_byte;
        logic              msg_last;
        logic [CRC_W-1:0]  crc;
    } t_item;

    // Eight steps of the long division, most significant message bit first.
    function automatic logic [CRC_W-1:0] crc_feed_byte(input logic [CRC_W-1:0] rem,
                                                       input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] r;
        logic             fb;
        r  = rem;
        fb = 1'b0;
        for (int k = 0; k < BYTE_W; k++) begin
            fb = r[CRC_W-1] ^ data[3'(BYTE_W - 1 - k)];
            r  = {r[CRC_W-2:0], 1'b0};
            if (fb) begin
                r = r ^ CRC_GEN;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/crc32ae_if.sv
`default_nettype none

interface crc32ae_in_if;
    import crc32ae_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] msg_byte;
    logic              msg_last;

    modport source (output valid, output msg_byte, output msg_last, input ready);
    modport sink   (input valid, input msg_byte, input msg_last, output ready);
endinterface

interface crc32ae_out_if;
    import crc32ae_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              is_check;
    logic              frame_end;

    modport source (output valid, output out_byte, output is_check, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input is_check, input frame_end,
                    output ready);
endinterface

`default_nettype wire

FILE: src/crc32ae_update.sv
`default_nettype none

module crc32ae_update (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    crc32ae_in_if.sink         i_in,
    input  wire logic          i_take,
    output logic               o_valid,
    output crc32ae_pkg::t_item o_item
);
    import crc32ae_pkg::*;

    logic             r_valid;
    logic [CRC_W-1:0] r_rem;
    t_item            r_item;
    logic [CRC_W-1:0] n_fed;
    logic             accept;

    // The stage frees up in the same cycle that the emitter takes its item.
    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_fed = crc_feed_byte(r_rem, i_in.msg_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rem   <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_rem   <= i_in.msg_last ? '0 : n_fed;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.msg_byte <= i_in.msg_byte;
            r_item.msg_last <= i_in.msg_last;
            r_item.crc      <= n_fed;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

FILE: src/crc32ae_emit.sv
`default_nettype none

module crc32ae_emit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire crc32ae_pkg::t_item  i_item,
    output logic                     o_take,
    crc32ae_out_if.source            o_out
);
    import crc32ae_pkg::*;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_is_check;
    logic              r_frame_end;
    logic [CRC_W-1:0]  r_crc;
    logic [CNT_W-1:0]  r_cnt;
    logic              free;
    logic              busy;

    assign free   = !r_out_valid || o_out.ready;
    assign busy   = (r_cnt != '0);
    assign o_take = i_valid && free && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (free) begin
            if (busy) begin
                r_out_valid <= 1'b1;
                r_cnt       <= r_cnt - CNT_W'(1);
            end else if (i_valid) begin
                r_out_valid <= 1'b1;
                r_cnt       <= i_item.msg_last ? CNT_W'(CHECK_BYTES) : '0;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Check bytes leave from the top of the captured CRC, which shifts up a byte each transfer.
    always_ff @(posedge i_clk) begin
        if (free) begin
            if (busy) begin
                r_out_byte  <= r_crc[CRC_W-1 -: BYTE_W];
                r_crc       <= {r_crc[CRC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
                r_is_check  <= 1'b1;
                r_frame_end <= (r_cnt == CNT_W'(1));
            end else if (i_valid) begin
                r_out_byte  <= i_item.msg_byte;
                r_crc       <= i_item.crc;
                r_is_check  <= 1'b0;
                r_frame_end <= 1'b0;
            end
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.is_check  = r_is_check;
    assign o_out.frame_end = r_frame_end;

endmodule

`default_nettype wire

FILE: src/crc32_append_encoder_top.sv
// A message byte is registered in the update stage and then in the emitter's output
// register, from which it is transferred out once the output is ready.
// Throughput: one byte per cycle while the output is ready; a final byte is followed
// by its four CRC bytes, and no new byte is taken until they have gone out.
// Reset: synchronous, active low; empties both stages and clears the remainder.
`default_nettype none

module crc32_append_encoder_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    crc32ae_in_if.sink     i_in,
    crc32ae_out_if.source  o_out
);
    import crc32ae_pkg::*;

    logic  item_valid;
    logic  item_take;
    t_item item;

    crc32ae_update u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (item_take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    crc32ae_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (item),
        .o_take  (item_take),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: src/crc32ae_checker.sv
`default_nettype none
`include "crc32_append_encoder_top_defines.svh"

module crc32ae_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic [7:0] i_out_byte,
    input wire logic i_is_check,
    input wire logic i_frame_end
);

    `CRC_ASSERT(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    `CRC_ASSERT_RST(a_end_is_check, i_clk, i_rst_n, i_out_valid |-> (!i_frame_end || i_is_check), "frame end on a message byte")

    `CRC_ASSERT_RST(a_check_run, i_clk, i_rst_n, (i_out_valid && i_out_ready && i_is_check && !i_frame_end) |=> (i_out_valid && i_is_check), "gap inside the CRC bytes")

    `CRC_ASSERT_RST(a_stall_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte) && $stable(i_is_check) && $stable(i_frame_end)), "stalled result changed")

endmodule

bind crc32_append_encoder_top crc32ae_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_is_check  (o_out.is_check),
    .i_frame_end (o_out.frame_end)
);

`default_nettype wire
